// ===== src/eida_pkg.sv =====
package eida_pkg;

   // Field widths of the request and response words
   localparam int CMD_W    = 3;
   localparam int ID_W     = 10;
   localparam int SIG_W    = 32;
   localparam int STATUS_W = 2;

   localparam int ENTITY_SLOTS_DEFAULT    = 1024;
   localparam int COMPONENT_KINDS_DEFAULT = 32;

   localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_SIG = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GET_SIG = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   // Free queue operations, at most one of pop and push per cycle
   typedef struct packed {
      logic restart;
      logic pop;
      logic push;
      logic fill;
   } fq_op_type;

   // Entity table port operations
   typedef struct packed {
      logic rd;
      logic wr;
   } tbl_op_type;

endpackage

// ===== src/eida_channels.sv =====
interface eida_req_if;
   logic                       valid;
   logic                       ready;
   logic [eida_pkg::CMD_W-1:0] command;
   logic [eida_pkg::ID_W-1:0]  entity_id;
   logic [eida_pkg::SIG_W-1:0] signature_in;

   modport source (output valid, command, entity_id, signature_in, input ready);
   modport sink (input valid, command, entity_id, signature_in, output ready);
endinterface

interface eida_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [eida_pkg::STATUS_W-1:0] status;
   logic [eida_pkg::ID_W-1:0]     new_entity_id;
   logic [eida_pkg::SIG_W-1:0]    signature_out;
   logic                          is_live;
   logic [eida_pkg::ID_W-1:0]     live_count;

   modport source (output valid, status, new_entity_id, signature_out, is_live, live_count,
                   input ready);
   modport sink (input valid, status, new_entity_id, signature_out, is_live, live_count,
                 output ready);
endinterface

// ===== src/entity_id_allocator_top.sv =====
// Path from acceptance to response word valid: an empty-queue create, an out-of-range id or
//   an unknown command go straight to S_RESP; destroy, query, set and get pass S_TREAD first,
//   create passes S_QREAD and S_TREAD. Each command holds the block until its result sits in
//   the output register; the queue read feeds the table read and the table read-modify-write,
//   one port each.
// Reset and clear sweep both memories, one entry a cycle, with ready low.
module entity_id_allocator_top #(
   parameter int ENTITY_SLOTS    = eida_pkg::ENTITY_SLOTS_DEFAULT,
   parameter int COMPONENT_KINDS = eida_pkg::COMPONENT_KINDS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   eida_req_if.sink   req_chan,
   eida_rsp_if.source rsp_chan
);

   localparam int SLOT_W  = $clog2(ENTITY_SLOTS);
   localparam int KIND_W  = (COMPONENT_KINDS < eida_pkg::SIG_W) ? COMPONENT_KINDS
                                                               : eida_pkg::SIG_W;
   localparam int ENTRY_W = KIND_W + 1;
   localparam int ID_W    = eida_pkg::ID_W;
   localparam int SIG_W   = eida_pkg::SIG_W;
   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(ENTITY_SLOTS - 1);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;  // sweep both memories
   localparam logic [2:0] S_IDLE  = 3'd1;  // take a request word
   localparam logic [2:0] S_QREAD = 3'd2;  // free queue head arrives
   localparam logic [2:0] S_TREAD = 3'd3;  // table entry arrives, write back
   localparam logic [2:0] S_RESP  = 3'd4;  // hand result to the output register

   logic [2:0]                    state_ff, state_in;
   logic [SLOT_W-1:0]             sweep_ff, sweep_in;
   logic                          item_ff, item_in;
   logic [eida_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic [SLOT_W-1:0]             addr_ff, addr_in;
   logic                          nonzero_ff, nonzero_in;
   logic [KIND_W-1:0]             sig_ff, sig_in;
   logic [SLOT_W-1:0]             alloc_ff, alloc_in;

   logic [eida_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]             res_id_ff, res_id_in;
   logic [KIND_W-1:0]             res_sig_ff, res_sig_in;
   logic                          res_live_ff, res_live_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [eida_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]               rsp_id_ff, rsp_id_in;
   logic [SIG_W-1:0]              rsp_sig_ff, rsp_sig_in;
   logic                          rsp_live_ff, rsp_live_in;
   logic [ID_W-1:0]               rsp_count_ff, rsp_count_in;

   eida_pkg::fq_op_type           fq_op;
   eida_pkg::tbl_op_type          tbl_op;
   logic [SLOT_W-1:0]             tbl_addr;
   logic [ENTRY_W-1:0]            tbl_wdata;
   logic [ENTRY_W-1:0]            tbl_rdata;
   logic [SLOT_W-1:0]             q_head_id;
   logic [SLOT_W-1:0]             q_free;

   logic [ID_W+SLOT_W-1:0]        req_id_wide;
   logic [SLOT_W-1:0]             req_addr;
   logic                          req_in_range;
   logic                          t_live;
   logic [KIND_W-1:0]             t_sig;
   logic [SLOT_W+ID_W-1:0]        res_id_wide;
   logic [SLOT_W+ID_W-1:0]        count_wide;
   logic [KIND_W+SIG_W-1:0]       res_sig_wide;

   eida_fqueue #(
      .ENTITY_SLOTS (ENTITY_SLOTS)
   ) u_fqueue (
      .clock      (clock),
      .reset      (reset),
      .op         (fq_op),
      .push_id    (addr_ff),
      .fill_addr  (sweep_ff),
      .head_id    (q_head_id),
      .free_count (q_free)
   );

   eida_etable #(
      .ENTITY_SLOTS    (ENTITY_SLOTS),
      .COMPONENT_KINDS (COMPONENT_KINDS)
   ) u_etable (
      .clock (clock),
      .op    (tbl_op),
      .addr  (tbl_addr),
      .wdata (tbl_wdata),
      .rdata (tbl_rdata)
   );

   // Fit the 10-bit id to the table address, whichever is wider
   assign req_id_wide  = {{SLOT_W{1'b0}}, req_chan.entity_id};
   assign req_addr     = req_id_wide[SLOT_W-1:0];
   assign req_in_range = {{(32-ID_W){1'b0}}, req_chan.entity_id} < 32'(ENTITY_SLOTS);

   assign t_live = tbl_rdata[KIND_W];
   assign t_sig  = tbl_rdata[KIND_W-1:0];

   assign res_id_wide  = {{ID_W{1'b0}}, res_id_ff};
   assign count_wide   = {{ID_W{1'b0}}, alloc_ff};
   assign res_sig_wide = {{SIG_W{1'b0}}, res_sig_ff};

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      item_in       = item_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      nonzero_in    = nonzero_ff;
      sig_in        = sig_ff;
      alloc_in      = alloc_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_sig_in    = res_sig_ff;
      res_live_in   = res_live_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_sig_in    = rsp_sig_ff;
      rsp_live_in   = rsp_live_ff;
      rsp_count_in  = rsp_count_ff;
      fq_op         = '0;
      tbl_op        = '0;
      tbl_addr      = addr_ff;
      tbl_wdata     = '0;

      // Drop the output word once the sink takes it
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            // Write one entry of each memory per cycle
            fq_op.fill = 1'b1;
            tbl_op.wr  = 1'b1;
            tbl_addr   = sweep_ff;
            tbl_wdata  = '0;
            if (sweep_ff == LAST) begin
               sweep_in = '0;
               state_in = item_ff ? S_RESP : S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_chan.valid) begin
               item_in       = 1'b1;
               cmd_in        = req_chan.command;
               addr_in       = req_addr;
               nonzero_in    = (req_chan.entity_id != '0);
               sig_in        = req_chan.signature_in[KIND_W-1:0];
               res_status_in = eida_pkg::STATUS_INVALID;
               res_id_in     = '0;
               res_sig_in    = '0;
               res_live_in   = 1'b0;
               state_in      = S_RESP;
               case (req_chan.command)
                  eida_pkg::CMD_CREATE: begin
                     if (q_free == '0) begin
                        res_status_in = eida_pkg::STATUS_NO_FREE;
                     end else begin
                        fq_op.pop = 1'b1;
                        state_in  = S_QREAD;
                     end
                  end
                  eida_pkg::CMD_DESTROY,
                  eida_pkg::CMD_QUERY,
                  eida_pkg::CMD_SET_SIG,
                  eida_pkg::CMD_GET_SIG: begin
                     // Out-of-range ids answer at once as invalid
                     if (req_in_range) begin
                        tbl_op.rd = 1'b1;
                        tbl_addr  = req_addr;
                        state_in  = S_TREAD;
                     end
                  end
                  eida_pkg::CMD_CLEAR: begin
                     fq_op.restart = 1'b1;
                     alloc_in      = '0;
                     sweep_in      = '0;
                     res_status_in = eida_pkg::STATUS_OK;
                     state_in      = S_CLEAR;
                  end
                  default: begin
                     res_status_in = eida_pkg::STATUS_INVALID;
                  end
               endcase
            end
         end

         S_QREAD: begin
            // Head id is here: fetch its table entry to keep its signature
            addr_in   = q_head_id;
            tbl_op.rd = 1'b1;
            tbl_addr  = q_head_id;
            state_in  = S_TREAD;
         end

         S_TREAD: begin
            res_status_in = eida_pkg::STATUS_OK;
            res_id_in     = '0;
            res_sig_in    = '0;
            res_live_in   = t_live;
            state_in      = S_RESP;
            case (cmd_ff)
               eida_pkg::CMD_CREATE: begin
                  tbl_op.wr   = 1'b1;
                  tbl_wdata   = {1'b1, t_sig};
                  alloc_in    = alloc_ff + 1'b1;
                  res_id_in   = addr_ff;
                  res_live_in = 1'b1;
               end
               eida_pkg::CMD_DESTROY: begin
                  if (nonzero_ff && t_live) begin
                     // Free the id: clear its entry and append it at the tail
                     tbl_op.wr   = 1'b1;
                     tbl_wdata   = '0;
                     fq_op.push  = 1'b1;
                     alloc_in    = alloc_ff - 1'b1;
                     res_live_in = 1'b0;
                  end else begin
                     res_status_in = eida_pkg::STATUS_INVALID;
                  end
               end
               eida_pkg::CMD_QUERY: begin
                  if (!(nonzero_ff && t_live)) begin
                     res_status_in = eida_pkg::STATUS_INVALID;
                     res_live_in   = 1'b0;
                  end
               end
               eida_pkg::CMD_SET_SIG: begin
                  tbl_op.wr = 1'b1;
                  tbl_wdata = {t_live, sig_ff};
               end
               eida_pkg::CMD_GET_SIG: begin
                  res_sig_in = t_sig;
               end
               default: begin
                  res_status_in = eida_pkg::STATUS_INVALID;
                  res_live_in   = 1'b0;
               end
            endcase
         end

         S_RESP: begin
            // Advance only when the output register is free or being emptied
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_wide[ID_W-1:0];
               rsp_sig_in    = res_sig_wide[SIG_W-1:0];
               rsp_live_in   = res_live_ff;
               rsp_count_in  = count_wide[ID_W-1:0];
               item_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         item_ff      <= 1'b0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         item_ff      <= item_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      nonzero_ff    <= nonzero_in;
      sig_ff        <= sig_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_sig_ff    <= res_sig_in;
      res_live_ff   <= res_live_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_sig_ff    <= rsp_sig_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.new_entity_id = rsp_id_ff;
   assign rsp_chan.signature_out = rsp_sig_ff;
   assign rsp_chan.is_live       = rsp_live_ff;
   assign rsp_chan.live_count    = rsp_count_ff;

   // Every nonzero id is either free in the queue or allocated; a create holds its
   // popped id between the queue read and the table write-back
   a_count_balance: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_QREAD && !(state_ff == S_TREAD && cmd_ff == eida_pkg::CMD_CREATE))
      |-> ((32'(q_free) + 32'(alloc_ff)) == (ENTITY_SLOTS - 1)))
      else $error("free and allocated counts out of balance");

   // The queue never hands out the invalid id
   a_create_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TREAD && cmd_ff == eida_pkg::CMD_CREATE) |-> (addr_ff != '0))
      else $error("create drew id zero from the free queue");

   // Without a word in flight the sequencer rests or sweeps
   a_idle_no_item: assert property (@(posedge clock) disable iff (reset)
      !item_ff |-> (state_ff == S_IDLE || state_ff == S_CLEAR))
      else $error("sequencer busy with no word in flight");

   // A sweep always starts at entry zero
   a_sweep_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR && state_in == S_CLEAR) |=> (sweep_ff == '0))
      else $error("sweep started away from entry zero");

endmodule

// ===== src/eida_fqueue.sv =====
module eida_fqueue #(
   parameter int ENTITY_SLOTS = eida_pkg::ENTITY_SLOTS_DEFAULT,
   localparam int SLOT_W = $clog2(ENTITY_SLOTS)
) (
   input  logic                clock,
   input  logic                reset,
   input  eida_pkg::fq_op_type op,
   input  logic [SLOT_W-1:0]   push_id,
   input  logic [SLOT_W-1:0]   fill_addr,
   output logic [SLOT_W-1:0]   head_id,
   output logic [SLOT_W-1:0]   free_count
);

   localparam logic [SLOT_W-1:0] LAST = SLOT_W'(ENTITY_SLOTS - 1);

   logic [SLOT_W-1:0] mem [ENTITY_SLOTS];

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic [SLOT_W-1:0] rdata_ff;
   logic              we;
   logic [SLOT_W-1:0] waddr;
   logic [SLOT_W-1:0] wdata;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      free_in = free_ff;
      if (op.restart) begin
         head_in = '0;
         tail_in = LAST;
         free_in = LAST;
      end else begin
         if (op.pop) begin
            head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
            free_in = free_ff - 1'b1;
         end
         if (op.push) begin
            tail_in = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;
            free_in = free_ff + 1'b1;
         end
      end
   end

   // The sweep lays down ids 1 to ENTITY_SLOTS-1, with 0 in the last entry
   assign we    = op.push | op.fill;
   assign waddr = op.fill ? fill_addr : tail_ff;
   assign wdata = op.fill ? ((fill_addr == LAST) ? '0 : fill_addr + 1'b1) : push_id;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (op.pop) begin
         rdata_ff <= mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= LAST;
         free_ff <= LAST;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         free_ff <= free_in;
      end
   end

   assign head_id    = rdata_ff;
   assign free_count = free_ff;

endmodule

// ===== src/eida_etable.sv =====
module eida_etable #(
   parameter int ENTITY_SLOTS    = eida_pkg::ENTITY_SLOTS_DEFAULT,
   parameter int COMPONENT_KINDS = eida_pkg::COMPONENT_KINDS_DEFAULT,
   localparam int SLOT_W  = $clog2(ENTITY_SLOTS),
   localparam int KIND_W  = (COMPONENT_KINDS < eida_pkg::SIG_W) ? COMPONENT_KINDS
                                                               : eida_pkg::SIG_W,
   localparam int ENTRY_W = KIND_W + 1
) (
   input  logic                 clock,
   input  eida_pkg::tbl_op_type op,
   input  logic [SLOT_W-1:0]    addr,
   input  logic [ENTRY_W-1:0]   wdata,
   output logic [ENTRY_W-1:0]   rdata
);

   // Entry layout: live mark on top, signature below
   logic [ENTRY_W-1:0] mem [ENTITY_SLOTS];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (op.wr) begin
         mem[addr] <= wdata;
      end
      if (op.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CLK_PERIOD  = 10;
   localparam int SLOTS       = eida_pkg::ENTITY_SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int TAIL_CYCLES = 24;
   // Response count at which the receiver holds off, and for how long
   localparam int SQUEEZE_AT  = 320;
   localparam int SQUEEZE_LEN = 400;

   typedef logic [eida_pkg::CMD_W-1:0]    cmd_type;
   typedef logic [eida_pkg::ID_W-1:0]     id_type;
   typedef logic [eida_pkg::SIG_W-1:0]    sig_type;
   typedef logic [eida_pkg::STATUS_W-1:0] status_type;

   typedef struct packed {
      status_type status;
      id_type     new_id;
      sig_type    signature;
      logic       live;
      id_type     live_count;
   } reply_type;

   // Mirror of the allocator: free ring, live marks and signatures, plus the
   // queue of response words still owed by the block.
   class allocator_scoreboard;
      id_type                      free_ring[SLOTS];
      id_type                      ring_head;
      id_type                      ring_tail;
      logic [eida_pkg::ID_W:0]     free_ids;
      bit                          live_mark[SLOTS];
      sig_type                     sig_store[SLOTS];
      id_type                      live_total;
      id_type                      live_ids[$];
      reply_type                   awaited_replies[$];
      int                          mismatches;

      function new();
         mismatches = 0;
         refill();
      endfunction

      function void refill();
         for (int i = 0; i < SLOTS; i++) begin
            free_ring[i] = (i + 1 < SLOTS) ? id_type'(i + 1) : '0;
            live_mark[i] = 1'b0;
            sig_store[i] = '0;
         end
         ring_head  = '0;
         ring_tail  = id_type'(SLOTS - 1);
         free_ids   = (eida_pkg::ID_W+1)'(SLOTS - 1);
         live_total = '0;
         live_ids.delete();
      endfunction

      // Work out the response to one accepted request word and queue it
      function void note_command(cmd_type cmd, id_type id, sig_type sig);
         reply_type r;
         r = '0;
         case (cmd)
            eida_pkg::CMD_CREATE: begin
               if (free_ids == 0) begin
                  r.status = eida_pkg::STATUS_NO_FREE;
               end else begin
                  r.new_id = free_ring[ring_head];
                  ring_head = ring_head + 1'b1;
                  free_ids = free_ids - 1'b1;
                  live_mark[r.new_id] = 1'b1;
                  live_total = live_total + 1'b1;
                  live_ids.insert(live_ids.size(), r.new_id);
                  r.live = 1'b1;
               end
            end
            eida_pkg::CMD_DESTROY: begin
               if (id != 0 && live_mark[id] && free_ids < SLOTS) begin
                  live_mark[id] = 1'b0;
                  sig_store[id] = '0;
                  free_ring[ring_tail] = id;
                  ring_tail = ring_tail + 1'b1;
                  free_ids = free_ids + 1'b1;
                  if (live_total > 0) live_total = live_total - 1'b1;
                  foreach (live_ids[k]) begin
                     if (live_ids[k] == id) begin
                        live_ids.delete(k);
                        break;
                     end
                  end
               end else begin
                  r.status = eida_pkg::STATUS_INVALID;
                  r.live = live_mark[id];
               end
            end
            eida_pkg::CMD_QUERY: begin
               if (id != 0 && live_mark[id]) r.live = 1'b1;
               else r.status = eida_pkg::STATUS_INVALID;
            end
            eida_pkg::CMD_SET_SIG: begin
               sig_store[id] = sig;
               r.live = live_mark[id];
            end
            eida_pkg::CMD_GET_SIG: begin
               r.signature = sig_store[id];
               r.live = live_mark[id];
            end
            eida_pkg::CMD_CLEAR: begin
               refill();
            end
            default: begin
               r.status = eida_pkg::STATUS_INVALID;
            end
         endcase
         r.live_count = live_total;
         awaited_replies.insert(awaited_replies.size(), r);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Compare one response word with the oldest one owed
      function void check_reply(reply_type got);
         reply_type want;
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %0h", $time, got);
            mismatches++;
            return;
         end
         want = awaited_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("new_entity_id", want.new_id, got.new_id);
         compare_field("signature_out", want.signature, got.signature);
         compare_field("is_live", want.live, got.live);
         compare_field("live_count", want.live_count, got.live_count);
      endfunction

      function id_type pick_live_id();
         if (live_ids.size() == 0) return id_type'($urandom_range(0, SLOTS - 1));
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   words_sent = 0;

   allocator_scoreboard ledger = new();

   eida_req_if req_chan();
   eida_rsp_if rsp_chan();

   entity_id_allocator_top #(
      .ENTITY_SLOTS   (SLOTS),
      .COMPONENT_KINDS(eida_pkg::COMPONENT_KINDS_DEFAULT)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog: drop out of the run if the block stops answering
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Gap length: mostly none or short, now and then long; none at all in a
   // quiet stretch so that words also go back to back.
   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request word, hold it until accepted, then note it and idle
   task automatic issue_word(input cmd_type cmd, input id_type id, input sig_type sig);
      int gap;
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.entity_id    <= id;
      req_chan.signature_in <= sig;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ledger.note_command(cmd, id, sig);
      words_sent++;
      gap = pick_gap(((words_sent / 80) % 5) == 2);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One random request word; weights in percent for create, destroy, clear
   // and unknown codes, the rest shared by query, set and get.
   task automatic random_word(input int w_create, input int w_destroy,
                              input int w_clear, input int w_bad);
      int      roll;
      cmd_type cmd;
      id_type  id;
      sig_type sig;
      roll = $urandom_range(0, 99);
      if (roll < w_create) cmd = eida_pkg::CMD_CREATE;
      else if (roll < w_create + w_destroy) cmd = eida_pkg::CMD_DESTROY;
      else if (roll < w_create + w_destroy + w_clear) cmd = eida_pkg::CMD_CLEAR;
      else if (roll < w_create + w_destroy + w_clear + w_bad)
         cmd = cmd_type'($urandom_range(6, 7));
      else begin
         case ($urandom_range(0, 2))
            0:       cmd = eida_pkg::CMD_QUERY;
            1:       cmd = eida_pkg::CMD_SET_SIG;
            default: cmd = eida_pkg::CMD_GET_SIG;
         endcase
      end
      // Aim mostly at live ids, sometimes anywhere, now and then at id zero
      roll = $urandom_range(0, 99);
      if (roll < 70) id = ledger.pick_live_id();
      else if (roll < 75) id = '0;
      else id = id_type'($urandom_range(0, SLOTS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 8) sig = '0;
      else if (roll < 16) sig = '1;
      else sig = sig_type'($urandom);
      issue_word(cmd, id, sig);
   endtask

   // Response side: check every accepted word and stall at random
   initial begin : reply_sink
      int        hold;
      int        replies;
      int        roll;
      reply_type got;
      hold = 0;
      replies = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status     = rsp_chan.status;
            got.new_id     = rsp_chan.new_entity_id;
            got.signature  = rsp_chan.signature_out;
            got.live       = rsp_chan.is_live;
            got.live_count = rsp_chan.live_count;
            ledger.check_reply(got);
            replies++;
            // Hold off for a long stretch once so that the block backs up
            if (replies == SQUEEZE_AT) hold = SQUEEZE_LEN;
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            roll = $urandom_range(0, 99);
            if (((replies / 70) % 5) != 3) begin
               if (roll < 20) hold = $urandom_range(1, 3);
               else if (roll < 23) hold = $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin : stimulus
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= eida_pkg::CMD_CREATE;
      req_chan.entity_id    <= '0;
      req_chan.signature_in <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words: id zero for set and get, the invalid id for query
      // and destroy, create order, signature cleared by destroy, destroy of
      // a dead id, top id, unknown codes and clear.
      issue_word(eida_pkg::CMD_GET_SIG, 10'd0, '0);
      issue_word(eida_pkg::CMD_SET_SIG, 10'd0, 32'hFFFF_FFFF);
      issue_word(eida_pkg::CMD_GET_SIG, 10'd0, '0);
      issue_word(eida_pkg::CMD_QUERY, 10'd0, '0);
      issue_word(eida_pkg::CMD_DESTROY, 10'd0, '0);
      issue_word(eida_pkg::CMD_CREATE, 10'd0, '0);
      issue_word(eida_pkg::CMD_QUERY, 10'd1, '0);
      issue_word(eida_pkg::CMD_SET_SIG, 10'd1, 32'hA5A5_5A5A);
      issue_word(eida_pkg::CMD_GET_SIG, 10'd1, '0);
      issue_word(eida_pkg::CMD_DESTROY, 10'd1, '0);
      issue_word(eida_pkg::CMD_GET_SIG, 10'd1, '0);
      issue_word(eida_pkg::CMD_DESTROY, 10'd1, '0);
      issue_word(eida_pkg::CMD_QUERY, 10'd1, '0);
      issue_word(eida_pkg::CMD_CREATE, 10'h3FF, 32'hFFFF_FFFF);
      issue_word(eida_pkg::CMD_SET_SIG, 10'h3FF, 32'hFFFF_FFFF);
      issue_word(eida_pkg::CMD_GET_SIG, 10'h3FF, '0);
      issue_word(eida_pkg::CMD_QUERY, 10'h3FF, '0);
      issue_word(eida_pkg::CMD_DESTROY, 10'h3FF, '0);
      issue_word(cmd_type'(6), 10'h155, 32'h5555_5555);
      issue_word(cmd_type'(7), 10'h2AA, 32'hAAAA_AAAA);
      issue_word(eida_pkg::CMD_SET_SIG, 10'h200, 32'h8000_0001);
      issue_word(eida_pkg::CMD_CLEAR, 10'd0, '0);
      issue_word(eida_pkg::CMD_GET_SIG, 10'h3FF, '0);
      issue_word(eida_pkg::CMD_CREATE, 10'd0, '0);

      // Mixed traffic with the odd clear
      repeat (200) random_word(30, 20, 1, 3);

      // Fill the pool until the free ring is empty; the head wraps on the way
      while (ledger.free_ids != 0) random_word(90, 3, 0, 1);

      // Churn around the empty ring: no-free creates and recycled ids
      repeat (60) random_word(45, 35, 0, 4);

      req_chan.valid <= 1'b0;
      while (ledger.awaited_replies.size() != 0) @(posedge clock);
      // Allow a spare response to show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);

      if (ledger.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
